// ===== rtl/sbc_pkg.sv =====
// ----------------------------------------------------------------------------
// sbc_pkg: shared constants, types and helpers
// Widths, fixed-point settings and the query context that travels
// alongside the impact-time dividers.
// ----------------------------------------------------------------------------
package sbc_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int CONTACT_OFFSET = 1;

    localparam int COORD_W = 32;
    localparam int TIME_W  = 31;
    localparam int NUM_W   = 35;
    localparam int DEN_W   = 33;
    localparam int REM_W   = DEN_W + TIME_W;
    localparam int PROD_W  = 64;
    localparam int DX_W    = PROD_W - FRAC_BITS;
    localparam int POS_W   = DX_W + 1;
    localparam int CMP_W   = POS_W + 2;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_RIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_BOTTOM = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_TOP    = 2'd3;

    localparam logic [1:0] NORM_ZERO = 2'b00;
    localparam logic [1:0] NORM_POS  = 2'b01;
    localparam logic [1:0] NORM_NEG  = 2'b11;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic signed [CMP_W-1:0] OFFSET_C = CMP_W'(CONTACT_OFFSET);

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
        logic [TIME_W-1:0]         side;
        logic [TIME_W-1:0]         limit;
        logic                      cand_x;
        logic                      cand_y;
        logic                      right_face;
        logic                      top_face;
    } t_ctx;

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] bottom;
        logic signed [COORD_W-1:0] top;
    } t_box;

    // Clamp a wide coordinate to the signed 32-bit range.
    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [CMP_W-1:0] v);
        logic signed [CMP_W-1:0] hi_c;
        logic signed [CMP_W-1:0] lo_c;
        hi_c = CMP_W'({1'b0, {(COORD_W-1){1'b1}}});
        lo_c = -hi_c - CMP_W'(1);
        if (v > hi_c) begin
            sat_coord = {1'b0, {(COORD_W-1){1'b1}}};
        end else if (v < lo_c) begin
            sat_coord = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            sat_coord = v[COORD_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/sbc_div.sv =====
// ----------------------------------------------------------------------------
// sbc_div: pipelined saturating divider
// Computes min((num << FRAC_BITS) / den, TIME_MAX), one quotient bit per
// stage, so a new word may enter every enabled cycle.
// ----------------------------------------------------------------------------
module sbc_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [sbc_pkg::NUM_W-1:0]   i_num,
    input  logic [sbc_pkg::DEN_W-1:0]   i_den,
    output logic [sbc_pkg::TIME_W-1:0]  o_q
);

    localparam int NS = sbc_pkg::TIME_W;

    logic [sbc_pkg::REM_W-1:0]  r_rem [NS];
    logic [sbc_pkg::DEN_W-1:0]  r_den [NS];
    logic [sbc_pkg::TIME_W-1:0] r_q   [NS];
    logic                       r_sat [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [sbc_pkg::REM_W-1:0]  rem_in;
        logic [sbc_pkg::DEN_W-1:0]  den_in;
        logic [sbc_pkg::TIME_W-1:0] q_in;
        logic                       sat_in;
        logic [sbc_pkg::REM_W-1:0]  trial;
        logic                       ge;

        if (k == 0) begin : g_first
            assign rem_in = sbc_pkg::REM_W'(i_num) << sbc_pkg::FRAC_BITS;
            assign den_in = i_den;
            assign q_in   = '0;
            // The quotient exceeds the time range when num >= den * 2^(TIME_W-FRAC_BITS).
            assign sat_in = sbc_pkg::REM_W'(i_num) >=
                            (sbc_pkg::REM_W'(i_den) << (sbc_pkg::TIME_W - sbc_pkg::FRAC_BITS));
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign q_in   = r_q[k-1];
            assign sat_in = r_sat[k-1];
        end

        assign trial = sbc_pkg::REM_W'(den_in) << (NS - 1 - k);
        assign ge    = rem_in >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? rem_in - trial : rem_in;
                r_den[k] <= den_in;
                r_q[k]   <= q_in | (sbc_pkg::TIME_W'(ge) << (NS - 1 - k));
                r_sat[k] <= sat_in;
            end
        end
    end

    assign o_q = r_sat[NS-1] ? sbc_pkg::TIME_MAX : r_q[NS-1];

endmodule

// ===== rtl/sbc_eval.sv =====
// ----------------------------------------------------------------------------
// sbc_eval: travel, overlap and result selection
// Three stages after the dividers: travel products, contact positions with
// overlap tests, then the x face before the y face against the running best.
// ----------------------------------------------------------------------------
module sbc_eval (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  sbc_pkg::t_ctx                i_ctx,
    input  sbc_pkg::t_box                i_box,
    input  logic [sbc_pkg::TIME_W-1:0]   i_tm_x,
    input  logic [sbc_pkg::TIME_W-1:0]   i_tm_y,
    output logic                         o_valid,
    output logic                         o_hit,
    output logic [sbc_pkg::TIME_W-1:0]   o_impact_time,
    output logic signed [sbc_pkg::COORD_W-1:0] o_contact_x,
    output logic signed [sbc_pkg::COORD_W-1:0] o_contact_y,
    output logic signed [1:0]            o_normal_x,
    output logic signed [1:0]            o_normal_y
);

    localparam int CW = sbc_pkg::CMP_W;

    // Stage A: products, and the x face held to the time limit.
    logic                               r_a_valid;
    sbc_pkg::t_ctx                      r_a_ctx;
    sbc_pkg::t_ctx                      n_a_ctx;
    logic [sbc_pkg::TIME_W-1:0]         r_a_tm_x, r_a_tm_y;
    logic signed [sbc_pkg::PROD_W-1:0]  r_a_pxx, r_a_pyx, r_a_pxy, r_a_pyy;

    always_comb begin
        n_a_ctx        = i_ctx;
        n_a_ctx.cand_x = i_ctx.cand_x && (i_tm_x < i_ctx.limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_ctx        <= n_a_ctx;
            r_a_tm_x       <= i_tm_x;
            r_a_tm_y       <= i_tm_y;
            r_a_pxx        <= i_ctx.vx * $signed({1'b0, i_tm_x});
            r_a_pyx        <= i_ctx.vy * $signed({1'b0, i_tm_x});
            r_a_pxy        <= i_ctx.vx * $signed({1'b0, i_tm_y});
            r_a_pyy        <= i_ctx.vy * $signed({1'b0, i_tm_y});
        end
    end

    // Stage B: positions at impact, overlap on the other axis, contacts.
    logic signed [sbc_pkg::DX_W-1:0] dxx, dyx, dxy, dyy;
    logic signed [CW-1:0] pxx, pyx, pxy, pyy;
    logic signed [CW-1:0] side_w, l2, r2, b2, t2;
    logic                 ov_x, ov_y;
    logic signed [CW-1:0] cxx, cyy;

    always_comb begin
        // An arithmetic shift of the product is the floor of the scaled travel.
        dxx = r_a_pxx[sbc_pkg::PROD_W-1:sbc_pkg::FRAC_BITS];
        dyx = r_a_pyx[sbc_pkg::PROD_W-1:sbc_pkg::FRAC_BITS];
        dxy = r_a_pxy[sbc_pkg::PROD_W-1:sbc_pkg::FRAC_BITS];
        dyy = r_a_pyy[sbc_pkg::PROD_W-1:sbc_pkg::FRAC_BITS];
        pxx = CW'(r_a_ctx.x) + CW'(dxx);
        pyx = CW'(r_a_ctx.y) + CW'(dyx);
        pxy = CW'(r_a_ctx.x) + CW'(dxy);
        pyy = CW'(r_a_ctx.y) + CW'(dyy);
        side_w = $signed(CW'(r_a_ctx.side));
        l2 = CW'(i_box.left) <<< 1;
        r2 = CW'(i_box.right) <<< 1;
        b2 = CW'(i_box.bottom) <<< 1;
        t2 = CW'(i_box.top) <<< 1;
        ov_x = ((pyx <<< 1) - side_w < t2) && ((pyx <<< 1) + side_w > b2);
        ov_y = ((pxy <<< 1) - side_w < r2) && ((pxy <<< 1) + side_w > l2);
        cxx = r_a_ctx.right_face ? pxx + sbc_pkg::OFFSET_C : pxx - sbc_pkg::OFFSET_C;
        cyy = r_a_ctx.top_face ? pyy + sbc_pkg::OFFSET_C : pyy - sbc_pkg::OFFSET_C;
    end

    logic                        r_b_valid;
    logic                        r_b_hit_x, r_b_hit_y;
    logic [sbc_pkg::TIME_W-1:0]  r_b_tm_x, r_b_tm_y, r_b_limit;
    logic [sbc_pkg::COORD_W-1:0] r_b_cx_x, r_b_cy_x, r_b_cx_y, r_b_cy_y;
    logic                        r_b_right, r_b_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_hit_x <= r_a_ctx.cand_x && ov_x;
            r_b_hit_y <= r_a_ctx.cand_y && ov_y;
            r_b_tm_x  <= r_a_tm_x;
            r_b_tm_y  <= r_a_tm_y;
            r_b_limit <= r_a_ctx.limit;
            r_b_cx_x  <= sbc_pkg::sat_coord(cxx);
            r_b_cy_x  <= sbc_pkg::sat_coord(pyx);
            r_b_cx_y  <= sbc_pkg::sat_coord(pxy);
            r_b_cy_y  <= sbc_pkg::sat_coord(cyy);
            r_b_right <= r_a_ctx.right_face;
            r_b_top   <= r_a_ctx.top_face;
        end
    end

    // Stage C: the y face must beat whatever the x face left as best.
    logic [sbc_pkg::TIME_W-1:0] best_x;
    logic                       hit_y;
    logic                       n_hit;
    logic [sbc_pkg::TIME_W-1:0] n_time;
    logic [sbc_pkg::COORD_W-1:0] n_cx, n_cy;
    logic [1:0]                 n_nx, n_ny;

    always_comb begin
        best_x = r_b_hit_x ? r_b_tm_x : r_b_limit;
        hit_y  = r_b_hit_y && (r_b_tm_y < best_x);
        n_hit  = r_b_hit_x || hit_y;
        n_time = best_x;
        n_cx   = '0;
        n_cy   = '0;
        n_nx   = sbc_pkg::NORM_ZERO;
        n_ny   = sbc_pkg::NORM_ZERO;
        if (hit_y) begin
            n_time = r_b_tm_y;
            n_cx   = r_b_cx_y;
            n_cy   = r_b_cy_y;
            n_ny   = r_b_top ? sbc_pkg::NORM_NEG : sbc_pkg::NORM_POS;
        end else if (r_b_hit_x) begin
            n_cx   = r_b_cx_x;
            n_cy   = r_b_cy_x;
            n_nx   = r_b_right ? sbc_pkg::NORM_NEG : sbc_pkg::NORM_POS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_hit         <= n_hit;
            o_impact_time <= n_time;
            o_contact_x   <= n_cx;
            o_contact_y   <= n_cy;
            o_normal_x    <= n_nx;
            o_normal_y    <= n_ny;
        end
    end

endmodule

// ===== rtl/swept_box_collision_solid.sv =====
// ----------------------------------------------------------------------------
// swept_box_collision_solid: swept square against a solid box
// Finds the earliest face impact of a moving square on a configured box.
// ----------------------------------------------------------------------------
// Usage:
// Queries enter on i_valid / o_stall; a word is taken at a rising edge with
// i_valid high and o_stall low. Results leave on o_valid / i_stall, one
// result word for every query, in order.
// The box edges are written through i_cfg_wr_en, i_cfg_index and
// i_cfg_data while no query is in flight.
// A word passes one setup register, 31 divider stages (one quotient bit
// each), two evaluation stages and the output register. Throughput is one
// query per cycle while no result is held on i_stall; the dividers for the
// x and y faces run side by side. The whole pipeline advances together;
// while a result waits on i_stall, o_stall is raised and nothing moves,
// so no word is lost or repeated.
// Reset clears all valid bits and sets the box edges to zero.
// ----------------------------------------------------------------------------
module swept_box_collision_solid (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [sbc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [31:0]                         i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [31:0]                  i_centre_x,
    input  logic signed [31:0]                  i_centre_y,
    input  logic signed [31:0]                  i_velocity_x,
    input  logic signed [31:0]                  i_velocity_y,
    input  logic [30:0]                         i_side_length,
    input  logic [30:0]                         i_time_limit,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_hit,
    output logic [30:0]                         o_impact_time,
    output logic signed [31:0]                  o_contact_x,
    output logic signed [31:0]                  o_contact_y,
    output logic signed [1:0]                   o_normal_x,
    output logic signed [1:0]                   o_normal_y
);

    localparam int NS = sbc_pkg::TIME_W;

    sbc_pkg::t_box r_box;
    logic          en;

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                sbc_pkg::REG_BOX_LEFT:   r_box.left   <= i_cfg_data;
                sbc_pkg::REG_BOX_RIGHT:  r_box.right  <= i_cfg_data;
                sbc_pkg::REG_BOX_BOTTOM: r_box.bottom <= i_cfg_data;
                sbc_pkg::REG_BOX_TOP:    r_box.top    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Setup: face selection, gaps and denominators in doubled coordinates.
    logic signed [sbc_pkg::NUM_W-1:0] lo_x, hi_x, lo_y, hi_y;
    logic signed [sbc_pkg::NUM_W-1:0] l2, r2, b2, t2;
    logic signed [sbc_pkg::NUM_W-1:0] n_num_x, n_num_y;
    logic signed [sbc_pkg::DEN_W-1:0] vx_w, vy_w, n_den_x, n_den_y;
    logic                             vx_neg, vx_pos, vy_neg, vy_pos;
    sbc_pkg::t_ctx                    n_ctx;

    always_comb begin
        lo_x = (sbc_pkg::NUM_W'(i_centre_x) <<< 1) - $signed(sbc_pkg::NUM_W'(i_side_length));
        hi_x = (sbc_pkg::NUM_W'(i_centre_x) <<< 1) + $signed(sbc_pkg::NUM_W'(i_side_length));
        lo_y = (sbc_pkg::NUM_W'(i_centre_y) <<< 1) - $signed(sbc_pkg::NUM_W'(i_side_length));
        hi_y = (sbc_pkg::NUM_W'(i_centre_y) <<< 1) + $signed(sbc_pkg::NUM_W'(i_side_length));
        l2 = sbc_pkg::NUM_W'(r_box.left) <<< 1;
        r2 = sbc_pkg::NUM_W'(r_box.right) <<< 1;
        b2 = sbc_pkg::NUM_W'(r_box.bottom) <<< 1;
        t2 = sbc_pkg::NUM_W'(r_box.top) <<< 1;
        vx_neg = i_velocity_x < 0;
        vx_pos = i_velocity_x > 0;
        vy_neg = i_velocity_y < 0;
        vy_pos = i_velocity_y > 0;
        vx_w = sbc_pkg::DEN_W'(i_velocity_x);
        vy_w = sbc_pkg::DEN_W'(i_velocity_y);
        n_den_x = (vx_neg ? -vx_w : vx_w) <<< 1;
        n_den_y = (vy_neg ? -vy_w : vy_w) <<< 1;
        n_num_x = vx_neg ? lo_x - r2 : l2 - hi_x;
        n_num_y = vy_neg ? lo_y - t2 : b2 - hi_y;
        n_ctx.x          = i_centre_x;
        n_ctx.y          = i_centre_y;
        n_ctx.vx         = i_velocity_x;
        n_ctx.vy         = i_velocity_y;
        n_ctx.side       = i_side_length;
        n_ctx.limit      = i_time_limit;
        n_ctx.cand_x     = (vx_neg && lo_x >= r2) || (vx_pos && hi_x <= l2);
        n_ctx.cand_y     = (vy_neg && lo_y >= t2) || (vy_pos && hi_y <= b2);
        n_ctx.right_face = vx_neg;
        n_ctx.top_face   = vy_neg;
    end

    logic                              r_s0_valid;
    sbc_pkg::t_ctx                     r_s0_ctx;
    logic [sbc_pkg::NUM_W-1:0]         r_num_x, r_num_y;
    logic [sbc_pkg::DEN_W-1:0]         r_den_x, r_den_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_ctx <= n_ctx;
            r_num_x  <= n_num_x;
            r_num_y  <= n_num_y;
            r_den_x  <= n_den_x;
            r_den_y  <= n_den_y;
        end
    end

    logic [sbc_pkg::TIME_W-1:0] tm_x, tm_y;

    sbc_div u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_num_x),
        .i_den (r_den_x),
        .o_q   (tm_x)
    );

    sbc_div u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_num_y),
        .i_den (r_den_y),
        .o_q   (tm_y)
    );

    // Context line running alongside the dividers.
    logic          r_d_valid [NS];
    sbc_pkg::t_ctx r_d_ctx   [NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_d_valid[k] <= 1'b0;
            end
        end else if (en) begin
            r_d_valid[0] <= r_s0_valid;
            for (int k = 1; k < NS; k++) begin
                r_d_valid[k] <= r_d_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_ctx[0] <= r_s0_ctx;
            for (int k = 1; k < NS; k++) begin
                r_d_ctx[k] <= r_d_ctx[k-1];
            end
        end
    end

    sbc_eval u_eval (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (r_d_valid[NS-1]),
        .i_ctx         (r_d_ctx[NS-1]),
        .i_box         (r_box),
        .i_tm_x        (tm_x),
        .i_tm_y        (tm_y),
        .o_valid       (o_valid),
        .o_hit         (o_hit),
        .o_impact_time (o_impact_time),
        .o_contact_x   (o_contact_x),
        .o_contact_y   (o_contact_y),
        .o_normal_x    (o_normal_x),
        .o_normal_y    (o_normal_y)
    );

endmodule

// ===== rtl/sbc_check.sv =====
// ----------------------------------------------------------------------------
// sbc_check: port-level checks
// Watches the top level's ports and flags inconsistent result words.
// ----------------------------------------------------------------------------
module sbc_check (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_stall,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic               o_hit,
    input  logic [30:0]        o_impact_time,
    input  logic signed [31:0] o_contact_x,
    input  logic signed [31:0] o_contact_y,
    input  logic signed [1:0]  o_normal_x,
    input  logic signed [1:0]  o_normal_y
);

    // A word without a hit carries no contact point and no normal.
    a_no_hit_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_contact_x == 0 && o_contact_y == 0 &&
                              o_normal_x == 0 && o_normal_y == 0)
        else $error("result without hit has contact data");

    // A hit names exactly one face.
    a_one_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> (o_normal_x == 0) != (o_normal_y == 0))
        else $error("hit normal is not a single face");

    // The input side only stalls behind a held result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_impact_time) && $stable(o_hit))
        else $error("stalled result word changed");

endmodule

bind swept_box_collision_solid sbc_check u_sbc_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_hit         (o_hit),
    .o_impact_time (o_impact_time),
    .o_contact_x   (o_contact_x),
    .o_contact_y   (o_contact_y),
    .o_normal_x    (o_normal_x),
    .o_normal_y    (o_normal_y)
);
